[sv/lpr_pkg.sv]
// Package for the LRU page-replacement block: sizes, channel and entry types.
// No dependencies; every other file of the block imports it.
package lpr_pkg;

    localparam int NUM_FRAMES = 16;
    localparam int PAGE_BITS  = 16;
    localparam int FRAME_W    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
    localparam int CFG_W      = 5;
    localparam int FAULT_W    = 16;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    // Input item: one page reference
    typedef struct packed {
        logic [15:0] page_number;
        logic        end_of_string;
    } lpr_in_t;

    // Result item
    typedef struct packed {
        logic        hit;
        logic [3:0]  frame_index;
        logic        evicted_valid;
        logic [15:0] evicted_page;
        logic [15:0] fault_total;
    } lpr_out_t;

    // One frame table entry as held in the memory
    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic [FRAME_W-1:0]   rank;
    } lpr_entry_t;

    // One entry handed from the memory read path to the scan unit
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] idx;
        logic               entry_valid;
    } lpr_probe_t;

    // What the scan over the active frames found
    typedef struct packed {
        logic                 hit_found;
        logic [FRAME_W-1:0]   hit_idx;
        logic [FRAME_W-1:0]   hit_rank;
        logic                 empty_found;
        logic [FRAME_W-1:0]   empty_idx;
        logic [FRAME_W-1:0]   lru_idx;
        logic [FRAME_W-1:0]   lru_rank;
        logic [PAGE_BITS-1:0] lru_page;
    } lpr_scan_t;

endpackage

[sv/lpr_frame_ram.sv]
// Frame table memory: page and recency rank per frame, one write and one read port.
// Depends on lpr_pkg for the entry type and depth.
module lpr_frame_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [lpr_pkg::FRAME_W-1:0] waddr,
    input  lpr_pkg::lpr_entry_t        wdata,
    input  logic                       re,
    input  logic [lpr_pkg::FRAME_W-1:0] raddr,
    output lpr_pkg::lpr_entry_t        rdata
);
    import lpr_pkg::*;

    lpr_entry_t mem [NUM_FRAMES];
    lpr_entry_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/lpr_scan_unit.sv]
// Scan unit: folds the frame entries, one per cycle, into hit, empty and LRU picks.
// Depends on lpr_pkg for the probe, entry and summary types.
module lpr_scan_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic [lpr_pkg::PAGE_BITS-1:0] page,
    input  lpr_pkg::lpr_probe_t          probe,
    input  lpr_pkg::lpr_entry_t          entry,
    output lpr_pkg::lpr_scan_t           summary
);
    import lpr_pkg::*;

    lpr_scan_t summary_reg;
    lpr_scan_t summary_next;

    // Fold one entry into the running picks
    always_comb
    begin
        summary_next = summary_reg;
        // first resident match wins
        if (probe.entry_valid && entry.page == page && !summary_reg.hit_found)
        begin
            summary_next.hit_found = 1'b1;
            summary_next.hit_idx   = probe.idx;
            summary_next.hit_rank  = entry.rank;
        end
        // highest-numbered empty frame wins, entries arrive in ascending order
        if (!probe.entry_valid)
        begin
            summary_next.empty_found = 1'b1;
            summary_next.empty_idx   = probe.idx;
        end
        // largest rank, first one on a tie; frame 0 seeds the pick
        if (probe.idx == '0 || entry.rank > summary_reg.lru_rank)
        begin
            summary_next.lru_idx  = probe.idx;
            summary_next.lru_rank = entry.rank;
            summary_next.lru_page = entry.page;
        end
    end

    // Hold the picks; clear them when a new item starts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            summary_reg <= '0;
        end
        else if (clear)
        begin
            summary_reg <= '0;
        end
        else if (probe.valid)
        begin
            summary_reg <= summary_next;
        end
    end

    assign summary = summary_reg;

endmodule

[sv/lru_page_replacement.sv]
// Channel    Signals                      Handshake
// request    start, request, busy         taken at a clock edge with start high, busy low
// result     done, result                 strobe, one cycle, cannot be held off
// config     cfg_we, cfg_wdata            written at a clock edge with cfg_we high
//
// An item keeps busy high through one pass over the active frames of the frame
// memory to look up the page, a decide state and one pass to rewrite the ranks, one
// read per cycle through the single read port. The next item is taken at the end
// of the first idle cycle, so a new item is not taken while the last one is busy.
// The result is registered from the decide state, ahead of the rewrite pass.
// An item that ends the string skips the rewrite pass.
// Reset clears the valid bits and fault count; no memory clearing pass is needed.
// busy stays high from acceptance to the last rank write, or to decide at a string end.
//
// Top level of the LRU page-replacement block: control, valid bits, fault counter.
// Depends on lpr_pkg, lpr_frame_ram and lpr_scan_unit.
module lru_page_replacement (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  lpr_pkg::lpr_in_t              request,
    output logic                          done,
    output lpr_pkg::lpr_out_t             result,
    input  logic                          cfg_we,
    input  logic [lpr_pkg::CFG_W-1:0]     cfg_wdata
);
    import lpr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      frames_reg;
    logic [CNT_W-1:0]      n_active;
    logic [NUM_FRAMES-1:0] valid_reg;
    logic [FAULT_W-1:0]    fault_reg;
    logic [CNT_W-1:0]      issue_reg;
    logic                  pend_reg;
    logic [FRAME_W-1:0]    ridx_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic                  last_reg;
    logic [FRAME_W-1:0]    f_reg;
    logic [FRAME_W-1:0]    old_rank_reg;
    logic                  old_inf_reg;
    logic                  done_reg;
    lpr_out_t              result_reg;

    logic                  accept;
    logic                  issue_more;
    logic                  pass_end;
    logic                  ram_we;
    lpr_entry_t            ram_wdata;
    lpr_entry_t            ram_rdata;
    lpr_probe_t            probe;
    lpr_scan_t             summary;

    logic [FRAME_W-1:0]    f_pick;
    logic [FRAME_W-1:0]    old_pick;
    logic                  old_inf_pick;
    logic                  ev_valid;
    logic [PAGE_BITS-1:0]  ev_page;
    logic [FAULT_W-1:0]    fault_next;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Clamp the frame count to 1..NUM_FRAMES
    always_comb
    begin
        if (frames_reg == '0)
        begin
            n_active = CNT_W'(1);
        end
        else if (32'(frames_reg) > NUM_FRAMES)
        begin
            n_active = CNT_W'(NUM_FRAMES);
        end
        else
        begin
            n_active = CNT_W'(frames_reg);
        end
    end

    // Read issue: one entry per cycle during either pass
    assign issue_more = (issue_reg < n_active) &&
                        (state_reg == ST_SCAN || state_reg == ST_UPDATE);
    assign pass_end   = (issue_reg == n_active) && pend_reg;

    // Memory; a pass reads entry j while writing entry j-1, so no overlap on one entry
    lpr_frame_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ridx_reg),
        .wdata (ram_wdata),
        .re    (issue_more),
        .raddr (issue_reg[FRAME_W-1:0]),
        .rdata (ram_rdata)
    );

    assign probe.valid       = pend_reg && (state_reg == ST_SCAN);
    assign probe.idx         = ridx_reg;
    assign probe.entry_valid = valid_reg[ridx_reg];

    lpr_scan_unit u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (accept),
        .page    (page_reg),
        .probe   (probe),
        .entry   (ram_rdata),
        .summary (summary)
    );

    // Pick the frame for this reference
    always_comb
    begin
        ev_valid     = 1'b0;
        ev_page      = '0;
        old_inf_pick = 1'b0;
        if (summary.hit_found)
        begin
            f_pick   = summary.hit_idx;
            old_pick = summary.hit_rank;
        end
        else if (summary.empty_found)
        begin
            f_pick       = summary.empty_idx;
            old_pick     = '0;
            old_inf_pick = 1'b1;
        end
        else
        begin
            f_pick   = summary.lru_idx;
            old_pick = summary.lru_rank;
            ev_valid = 1'b1;
            ev_page  = summary.lru_page;
        end
        if (!summary.hit_found && fault_reg != FAULT_MAX)
        begin
            fault_next = fault_reg + FAULT_W'(1);
        end
        else
        begin
            fault_next = fault_reg;
        end
    end

    // Rewrite pass: chosen frame to rank 0, more recent valid frames age by one
    always_comb
    begin
        ram_we    = pend_reg && (state_reg == ST_UPDATE);
        ram_wdata = ram_rdata;
        if (ridx_reg == f_reg)
        begin
            ram_wdata.page = page_reg;
            ram_wdata.rank = '0;
        end
        else if (valid_reg[ridx_reg] && (old_inf_reg || ram_rdata.rank < old_rank_reg))
        begin
            ram_wdata.rank = ram_rdata.rank + FRAME_W'(1);
        end
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pass_end)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = last_reg ? ST_IDLE : ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (pass_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, valid bits, fault counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            frames_reg <= CFG_W'(3);
            valid_reg  <= '0;
            fault_reg  <= '0;
            issue_reg  <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DECIDE);
            pend_reg  <= issue_more;
            if (issue_more)
            begin
                issue_reg <= issue_reg + CNT_W'(1);
            end
            else if (state_reg == ST_IDLE || state_reg == ST_DECIDE)
            begin
                issue_reg <= '0;
            end
            // a register write clears the table like the end of a string
            if (cfg_we)
            begin
                frames_reg <= cfg_wdata;
                valid_reg  <= '0;
                fault_reg  <= '0;
            end
            else if (state_reg == ST_DECIDE)
            begin
                if (last_reg)
                begin
                    valid_reg <= '0;
                    fault_reg <= '0;
                end
                else
                begin
                    valid_reg[f_pick] <= 1'b1;
                    fault_reg         <= fault_next;
                end
            end
        end
    end

    // Item payload, decision and result registers
    always_ff @(posedge clk)
    begin
        if (issue_more)
        begin
            ridx_reg <= issue_reg[FRAME_W-1:0];
        end
        if (accept)
        begin
            page_reg <= PAGE_BITS'(request.page_number);
            last_reg <= request.end_of_string;
        end
        if (state_reg == ST_DECIDE)
        begin
            f_reg                    <= f_pick;
            old_rank_reg             <= old_pick;
            old_inf_reg              <= old_inf_pick;
            result_reg.hit           <= summary.hit_found;
            result_reg.frame_index   <= 4'(f_pick);
            result_reg.evicted_valid <= ev_valid;
            result_reg.evicted_page  <= 16'(ev_page);
            result_reg.fault_total   <= 16'(fault_next);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[bench/lru_page_replacement_tb.sv]
// Self-checking bench for the LRU page-replacement block: directed references and
// random reference strings over many frame counts.
// Depends on lpr_pkg and lru_page_replacement; results are checked by a local LRU model.
`timescale 1ns / 100ps

module lru_page_replacement_tb;

    import lpr_pkg::*;

    typedef enum bit {ROW_REF, ROW_CFG} row_kind_t;

    // One directed step: either a frame-count write or a page reference
    typedef struct packed {
        row_kind_t   kind;
        logic [4:0]  frames;
        lpr_in_t     req;
        bit          typed;
        lpr_out_t    want;
    } dir_row_t;

    localparam int DIR_ROWS     = 24;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 155;
    localparam int SETTLE_WAIT  = 40;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    lpr_in_t             request;
    logic                done;
    lpr_out_t            result;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_wdata;

    // Local copy of the frame table
    logic [PAGE_BITS-1:0] frame_page [NUM_FRAMES];
    bit                   frame_live [NUM_FRAMES];
    int                   frame_age  [NUM_FRAMES];
    logic [FAULT_W-1:0]   fault_seen;
    logic [CFG_W-1:0]     frame_limit;

    lpr_out_t             pending_outcomes [$];
    int                   fail_count;

    // Directed references; typed rows carry outcomes that follow directly from the rules
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_REF, 5'd0,  {16'h0000, 1'b0}, 1'b1, {1'b0, 4'd2,  1'b0, 16'h0000, 16'd1}},
        '{ROW_REF, 5'd0,  {16'hFFFF, 1'b0}, 1'b1, {1'b0, 4'd1,  1'b0, 16'h0000, 16'd2}},
        '{ROW_REF, 5'd0,  {16'h0000, 1'b0}, 1'b1, {1'b1, 4'd2,  1'b0, 16'h0000, 16'd2}},
        '{ROW_REF, 5'd0,  {16'h1234, 1'b0}, 1'b1, {1'b0, 4'd0,  1'b0, 16'h0000, 16'd3}},
        '{ROW_REF, 5'd0,  {16'h5555, 1'b0}, 1'b0, '0},
        '{ROW_REF, 5'd0,  {16'hFFFF, 1'b1}, 1'b0, '0},
        '{ROW_REF, 5'd0,  {16'hAAAA, 1'b0}, 1'b1, {1'b0, 4'd2,  1'b0, 16'h0000, 16'd1}},
        '{ROW_REF, 5'd0,  {16'hAAAA, 1'b1}, 1'b1, {1'b1, 4'd2,  1'b0, 16'h0000, 16'd1}},
        '{ROW_CFG, 5'd1,  '0,               1'b0, '0},
        '{ROW_REF, 5'd0,  {16'h0007, 1'b0}, 1'b1, {1'b0, 4'd0,  1'b0, 16'h0000, 16'd1}},
        '{ROW_REF, 5'd0,  {16'h0007, 1'b0}, 1'b1, {1'b1, 4'd0,  1'b0, 16'h0000, 16'd1}},
        '{ROW_REF, 5'd0,  {16'h0008, 1'b0}, 1'b1, {1'b0, 4'd0,  1'b1, 16'h0007, 16'd2}},
        '{ROW_CFG, 5'd0,  '0,               1'b0, '0},
        '{ROW_REF, 5'd0,  {16'h8000, 1'b0}, 1'b1, {1'b0, 4'd0,  1'b0, 16'h0000, 16'd1}},
        '{ROW_REF, 5'd0,  {16'h0001, 1'b0}, 1'b1, {1'b0, 4'd0,  1'b1, 16'h8000, 16'd2}},
        '{ROW_CFG, 5'd31, '0,               1'b0, '0},
        '{ROW_REF, 5'd0,  {16'h0001, 1'b0}, 1'b1, {1'b0, 4'd15, 1'b0, 16'h0000, 16'd1}},
        '{ROW_REF, 5'd0,  {16'h0002, 1'b0}, 1'b1, {1'b0, 4'd14, 1'b0, 16'h0000, 16'd2}},
        '{ROW_CFG, 5'd16, '0,               1'b0, '0},
        '{ROW_REF, 5'd0,  {16'hFFFF, 1'b0}, 1'b1, {1'b0, 4'd15, 1'b0, 16'h0000, 16'd1}},
        '{ROW_REF, 5'd0,  {16'hFFFF, 1'b1}, 1'b1, {1'b1, 4'd15, 1'b0, 16'h0000, 16'd1}},
        '{ROW_REF, 5'd0,  {16'h4321, 1'b0}, 1'b1, {1'b0, 4'd15, 1'b0, 16'h0000, 16'd1}},
        '{ROW_CFG, 5'd3,  '0,               1'b0, '0},
        '{ROW_REF, 5'd0,  {16'h4321, 1'b0}, 1'b1, {1'b0, 4'd2,  1'b0, 16'h0000, 16'd1}}
    };

    lru_page_replacement DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Drop every resident page and restart the fault count
    function automatic void wipe_frames();
        int j;
        for (j = 0; j < NUM_FRAMES; j++)
        begin
            frame_page[j] = '0;
            frame_live[j] = 1'b0;
            frame_age[j]  = 0;
        end
        fault_seen = '0;
    endfunction

    // Look up one reference, update the local table and return its outcome
    function automatic lpr_out_t lru_predict(lpr_in_t r);
        lpr_out_t o;
        int       n;
        int       f;
        int       j;
        int       best;
        int       old_age;
        bit       hit;
        bit       found;
        o = '0;
        n = (frame_limit == 0) ? 1 :
            ((frame_limit > NUM_FRAMES) ? NUM_FRAMES : int'(frame_limit));
        hit = 1'b0;
        f = 0;
        for (j = 0; j < n; j++)
        begin
            if (!hit && frame_live[j] && frame_page[j] == r.page_number)
            begin
                f = j;
                hit = 1'b1;
            end
        end
        // Pick a victim: highest empty frame above 0, then frame 0, then the oldest
        if (!hit)
        begin
            found = 1'b0;
            for (j = n - 1; j >= 1; j--)
            begin
                if (!found && !frame_live[j])
                begin
                    f = j;
                    found = 1'b1;
                end
            end
            if (!found && !frame_live[0])
            begin
                f = 0;
                found = 1'b1;
            end
            if (!found)
            begin
                best = 0;
                f = 0;
                for (j = 0; j < n; j++)
                begin
                    if (frame_age[j] > best)
                    begin
                        best = frame_age[j];
                        f = j;
                    end
                end
                o.evicted_valid = 1'b1;
                o.evicted_page  = frame_page[f];
            end
            if (fault_seen != FAULT_MAX)
                fault_seen = fault_seen + 1'b1;
        end
        // Age every frame that was more recent than the touched one
        old_age = frame_live[f] ? frame_age[f] : 255;
        for (j = 0; j < n; j++)
        begin
            if (j != f && frame_live[j] && frame_age[j] < old_age)
                frame_age[j] = frame_age[j] + 1;
        end
        frame_age[f]  = 0;
        frame_live[f] = 1'b1;
        if (!hit)
            frame_page[f] = r.page_number;
        o.hit         = hit;
        o.frame_index = f[3:0];
        o.fault_total = fault_seen;
        if (r.end_of_string)
            wipe_frames();
        return o;
    endfunction

    // Offer one reference and hold it until the block takes it
    task automatic send_ref(lpr_in_t r, bit typed, lpr_out_t want);
        lpr_out_t p;
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        p = lru_predict(r);
        pending_outcomes.push_back(typed ? want : p);
    endtask

    // Stop sending and wait until every outcome is in and the block is idle
    task automatic drain();
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Write the frame count; the block also clears its table
    task automatic set_frames(logic [CFG_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        frame_limit = v;
        wipe_frames();
    endtask

    // Check each result against the oldest outcome waiting
    always @(posedge clk)
    begin
        lpr_out_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_outcomes.size() == 0)
            begin
                fail_count++;
                $error("result with no outcome waiting: %h", result);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (result !== want)
                begin
                    fail_count++;
                    if (result.hit !== want.hit)
                        $error("hit: expected %0d, got %0d", want.hit, result.hit);
                    if (result.frame_index !== want.frame_index)
                        $error("frame_index: expected %0d, got %0d",
                               want.frame_index, result.frame_index);
                    if (result.evicted_valid !== want.evicted_valid)
                        $error("evicted_valid: expected %0d, got %0d",
                               want.evicted_valid, result.evicted_valid);
                    if (result.evicted_page !== want.evicted_page)
                        $error("evicted_page: expected %h, got %h",
                               want.evicted_page, result.evicted_page);
                    if (result.fault_total !== want.fault_total)
                        $error("fault_total: expected %0d, got %0d",
                               want.fault_total, result.fault_total);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int                   i;
        int                   p;
        int                   k;
        int                   n;
        int                   pool_size;
        bit                   idle_ok;
        bit                   idle_on;
        logic [CFG_W-1:0]     v;
        logic [PAGE_BITS-1:0] pool [20];
        lpr_in_t              r;
        logic [CFG_W-1:0]     phase_frames [RAND_PHASES];

        phase_frames = '{5'd2, 5'd16, 5'd1, 5'd4, 5'd31, 5'd8, 5'd0, 5'd15, 5'd3, 5'd16};
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        fail_count = 0;
        frame_limit = 5'd3;
        wipe_frames();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
                set_frames(dir_rows[i].frames);
            else
                send_ref(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random reference strings, each phase at its own frame count
        for (p = 0; p < RAND_PHASES; p++)
        begin
            v = (p == RAND_PHASES - 2) ? 5'($urandom_range(0, 31)) : phase_frames[p];
            set_frames(v);
            n = (v == 0) ? 1 : ((v > NUM_FRAMES) ? NUM_FRAMES : int'(v));
            // Keep the working set near the frame count so hits and evictions both occur
            pool_size = n + $urandom_range(0, 3);
            if (pool_size > 20)
                pool_size = 20;
            for (k = 0; k < 20; k++)
                pool[k] = 16'($urandom);
            idle_ok = (p != RAND_PHASES - 1);
            idle_on = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 30 == 0)
                    idle_on = $urandom_range(0, 1);
                if ($urandom_range(0, 99) < 85)
                    r.page_number = pool[$urandom_range(0, pool_size - 1)];
                else
                    r.page_number = 16'($urandom);
                r.end_of_string = ($urandom_range(0, 49) == 0);
                send_ref(r, 1'b0, '0);
                if (idle_ok && idle_on && $urandom_range(0, 3) == 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end
        end

        // Let the last results arrive, then settle
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        if (fail_count == 0 && pending_outcomes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
sv/lpr_pkg.sv
sv/lpr_frame_ram.sv
sv/lpr_scan_unit.sv
sv/lru_page_replacement.sv
bench/lru_page_replacement_tb.sv
